FILE: design/eld_pkg.sv
// eld_pkg: types and register indexes for the escaped length deframer
// no dependencies
package eld_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CNT_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd3;

  typedef struct packed {
    logic [31:0] error_count;
    logic [15:0] packet_length;
    logic        packet_done;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic        payload_valid;
  } res_t;

endpackage

FILE: design/escaped_length_deframer.sv
// escaped_length_deframer: byte-stuffed, length-prefixed frame receiver
// each accepted request's result is registered in the output register, or in the skid
// entry when the output stalls; one request per cycle sustained while the skid entry is
// empty, the single-pass byte decode sets that figure; a two-entry output stage keeps accepting while a result waits
// reset (rst_n low, synchronous) clears frame state, error count and registers to defaults
// depends on eld_pkg
module escaped_length_deframer
  import eld_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,  // payload_byte, payload_index, packet_length, error_count
  output logic                  out_tlast,  // packet_done
  output logic                  out_tuser   // payload_valid
);

  logic [7:0]       start_byte_r;
  logic [7:0]       escape_byte_r;
  logic [7:0]       escape_offset_r;
  logic [15:0]      max_payload_r;

  logic             escape_pending_r, escape_pending_nxt;
  logic [CNT_W-1:0] received_count_r, received_count_nxt;
  logic [15:0]      length_value_r, length_value_nxt;
  logic             frame_in_error_r, frame_in_error_nxt;
  logic [31:0]      error_counter_r, error_counter_nxt;

  logic             out_valid_r;
  res_t             out_data_r;
  logic             skid_valid_r;
  res_t             skid_data_r;

  res_t             res;
  logic             in_accept;
  logic [7:0]       b;
  logic [15:0]      len_full;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    escape_pending_nxt = escape_pending_r;
    received_count_nxt = received_count_r;
    length_value_nxt   = length_value_r;
    frame_in_error_nxt = frame_in_error_r;
    error_counter_nxt  = error_counter_r;
    res                = '0;
    b                  = in_tdata;
    len_full           = {in_tdata, length_value_r[7:0]};
    if (in_tdata == start_byte_r) begin
      if (received_count_r != '0) begin
        error_counter_nxt = error_counter_r + 32'd1;
      end
      received_count_nxt = '0;
      escape_pending_nxt = 1'b0;
      length_value_nxt   = '0;
      frame_in_error_nxt = 1'b0;
    end else if (in_tdata == escape_byte_r) begin
      escape_pending_nxt = 1'b1;
    end else begin
      if (escape_pending_r) begin
        b = in_tdata - escape_offset_r;
        escape_pending_nxt = 1'b0;
      end
      len_full = {b, length_value_r[7:0]};
      if (received_count_r == CNT_W'(0)) begin
        length_value_nxt   = {8'd0, b};
        received_count_nxt = CNT_W'(1);
      end else if (received_count_r == CNT_W'(1)) begin
        length_value_nxt   = len_full;
        received_count_nxt = CNT_W'(2);
        if (len_full > max_payload_r) begin
          frame_in_error_nxt = 1'b1;
          error_counter_nxt  = error_counter_r + 32'd1;
        end else if (len_full == 16'd0) begin
          res.packet_done    = 1'b1;
          received_count_nxt = '0;
        end
      end else if (!frame_in_error_r) begin
        res.payload_valid = 1'b1;
        res.payload_byte  = b;
        res.payload_index = 16'(received_count_r - CNT_W'(2));
        if (received_count_r - CNT_W'(1) == {1'b0, length_value_r}) begin
          res.packet_done    = 1'b1;
          received_count_nxt = '0;
        end else begin
          received_count_nxt = received_count_r + CNT_W'(1);
        end
      end
    end
    res.packet_length = length_value_nxt;
    res.error_count   = error_counter_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r    <= 8'd126;
      escape_byte_r   <= 8'd125;
      escape_offset_r <= 8'd32;
      max_payload_r   <= 16'd1024;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_START_BYTE:    start_byte_r    <= cfg_wdata[7:0];
        REG_ESCAPE_BYTE:   escape_byte_r   <= cfg_wdata[7:0];
        REG_ESCAPE_OFFSET: escape_offset_r <= cfg_wdata[7:0];
        REG_MAX_PAYLOAD:   max_payload_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_pending_r <= 1'b0;
      received_count_r <= '0;
      length_value_r   <= '0;
      frame_in_error_r <= 1'b0;
      error_counter_r  <= '0;
    end else if (in_accept) begin
      escape_pending_r <= escape_pending_nxt;
      received_count_r <= received_count_nxt;
      length_value_r   <= length_value_nxt;
      frame_in_error_r <= frame_in_error_nxt;
      error_counter_r  <= error_counter_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else begin
        out_data_r <= res;
      end
    end else if (in_accept) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.error_count, out_data_r.packet_length,
                       out_data_r.payload_index, out_data_r.payload_byte};
  assign out_tlast  = out_data_r.packet_done;
  assign out_tuser  = out_data_r.payload_valid;

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid entry filled while output was free");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.packet_done && out_data_r.payload_valid) |->
      (out_data_r.payload_index + 16'd1 == out_data_r.packet_length))
    else $error("last payload byte index does not match length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (received_count_r > CNT_W'(2) && !frame_in_error_r) |->
      (received_count_r - CNT_W'(2) < {1'b0, length_value_r}))
    else $error("payload count ran past frame length");
`endif

endmodule
